### src/muon_tile_table_index_defines.svh
// Assertion macros shared by the tile table index block.
`ifndef MUON_TILE_TABLE_INDEX_DEFINES_SVH
`define MUON_TILE_TABLE_INDEX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTTI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mtti_pkg.sv
package mtti_pkg;

    // Table organization.
    localparam int NumStations       = 4;
    localparam int NumRegions        = 4;
    localparam int RegionsPerStation = 4;
    localparam int EntryCount        = 16;
    localparam int EntryAw           = $clog2(EntryCount);

    // Field widths.
    localparam int GridW  = 8;
    localparam int StripW = 20;
    localparam int PointW = 20;
    localparam int SizeW  = 16;

    // Arithmetic constants of the index formulas.
    localparam int SizeStep       = 24;
    localparam int PerQuarterMul  = 3;
    localparam int SizeQuarterMul = 6;

    // Internal datapath widths.
    localparam int ProdW = 2 * GridW;
    localparam int KW    = 6;
    localparam int Q6W   = 5;
    localparam int BaseW = 23;
    localparam int OffsW = 19;
    localparam int PtW   = 24;
    localparam int SzpW  = 17;
    localparam int SzW   = 19;

    // Divider geometry.
    localparam int DividendW       = GridW + 1;
    localparam int DivStepsPerCycle = 3;
    localparam int DivCycles       = DividendW / DivStepsPerCycle;
    localparam int DivCntW         = $clog2(DivCycles);

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_PAD    = 2'd1,
        ACT_STRIP  = 2'd2,
        ACT_IGNORE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LOADED     = 2'd1,
        ST_ZERO_WIDTH = 2'd2,
        ST_RANGE      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [GridW-1:0]  grid_width;
        logic [GridW-1:0]  grid_height;
        logic [StripW-1:0] strip_base;
        logic [SizeW-1:0]  size_base;
    } t_entry;

    typedef struct packed {
        logic                 start;
        logic [DividendW-1:0] dividend;
        logic [GridW-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DividendW-1:0] quotient;
    } t_div_rsp;

endpackage

### src/mtti_ram.sv
module mtti_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mtti_div.sv
`include "muon_tile_table_index_defines.svh"

module mtti_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtti_pkg::t_div_req i_req,
    output mtti_pkg::t_div_rsp o_rsp
);

    logic                                   r_busy;
    logic                                   r_done;
    logic [mtti_pkg::DivCntW-1:0]           r_cnt;
    logic [mtti_pkg::GridW-1:0]             r_rem;
    logic [mtti_pkg::DividendW-1:0]         r_dq;
    logic [mtti_pkg::GridW-1:0]             r_den;
    logic [mtti_pkg::GridW-1:0]             w_rem;
    logic [mtti_pkg::DividendW-1:0]         w_dq;
    logic [mtti_pkg::GridW:0]               w_trial;
    logic                                   w_last;

    // Restoring division, a few quotient bits per cycle. The dividend bits
    // shift out of the top of r_dq while quotient bits shift in at the bottom.
    always_comb begin
        w_rem   = r_rem;
        w_dq    = r_dq;
        w_trial = '0;
        for (int i = 0; i < mtti_pkg::DivStepsPerCycle; i++) begin
            w_trial = {w_rem, w_dq[mtti_pkg::DividendW-1]};
            w_dq    = {w_dq[mtti_pkg::DividendW-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                w_rem   = mtti_pkg::GridW'(w_trial - {1'b0, r_den});
                w_dq[0] = 1'b1;
            end else begin
                w_rem = w_trial[mtti_pkg::GridW-1:0];
            end
        end
    end

    assign w_last = (r_cnt == mtti_pkg::DivCntW'(mtti_pkg::DivCycles - 1));

    // Sequencing of the iterations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Partial remainder and dividend/quotient word.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dq  <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_dq  <= w_dq;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dq;

    `MTTI_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, i_req.start, r_busy && !r_done, "divider did not begin after start")
    `MTTI_ASSERT_IMPL(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider reports done while still busy")
    `MTTI_ASSERT_IMPL(a_div_rem_bound, i_clk, i_rst_n, r_done && (r_den != '0), r_rem < r_den, "divider remainder not below divisor")

endmodule

### src/muon_tile_table_index.sv
// Tile table index unit.
// Input channel (i_in_valid / o_in_ready) carries one item: a table load or a
// pad or strip lookup of a tile ID. Output channel (o_out_valid / i_out_ready)
// returns exactly one result item for every input item, in order.
// A lookup passes through S_READ, reading the 16-entry table memory and
// forming the grid products, S_MUL, the multiply, S_DIV, waiting for the
// divider that yields three quotient bits per cycle and was started in
// S_READ, and S_DONE, loading the output register. Loads and refused items
// go straight to S_DONE, a zero-width lookup from S_READ to S_DONE.
// Items are worked one at a time and o_in_ready returns the cycle after the
// result is loaded.
// Loads write the table memory directly at acceptance and keep a running size
// base sum; loading entry 0 restarts that sum from zero.
// Reset clears the running sum and the per-entry valid bits, so every entry
// reads as zero until it is loaded; no clearing pass is needed.
// A finished result sits in the output register. The block accepts the next
// item while it waits; if the receiver still stalls when that item finishes,
// the block holds it and drops o_in_ready until the register frees.
`include "muon_tile_table_index_defines.svh"

module muon_tile_table_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_action,
    input  logic [1:0]                    i_station,
    input  logic [1:0]                    i_region,
    input  logic [1:0]                    i_quarter,
    input  logic [7:0]                    i_pad_x,
    input  logic [7:0]                    i_pad_y,
    input  logic [mtti_pkg::GridW-1:0]    i_load_grid_x,
    input  logic [mtti_pkg::GridW-1:0]    i_load_grid_y,
    input  logic [mtti_pkg::StripW-1:0]   i_load_strip_base,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mtti_pkg::PointW-1:0]   o_point_index,
    output logic [mtti_pkg::SizeW-1:0]    o_size_idx,
    output logic [1:0]                    o_status
);

    mtti_pkg::t_state                    r_state;
    mtti_pkg::t_state                    n_state;
    mtti_pkg::t_action                   w_action;
    mtti_pkg::t_action                   r_act;
    mtti_pkg::t_status                   r_pend;
    mtti_pkg::t_status                   r_out_status;
    mtti_pkg::t_entry                    w_wdata;
    mtti_pkg::t_entry                    w_ent;
    mtti_pkg::t_div_req                  w_div_req;
    mtti_pkg::t_div_rsp                  w_div_rsp;

    logic                                w_in_acc;
    logic                                w_in_range;
    logic                                w_load;
    logic                                w_lookup;
    logic [mtti_pkg::EntryAw-1:0]        w_entry;
    logic [mtti_pkg::SizeW-1:0]          r_sum;
    logic [mtti_pkg::SizeW-1:0]          w_sum_base;
    logic [mtti_pkg::EntryCount-1:0]     r_valid;
    logic [$bits(mtti_pkg::t_entry)-1:0] w_rdata;
    logic                                w_out_free;
    logic                                w_out_load;

    // Item fields held for the lookup.
    logic                                r_hit;
    logic [1:0]                          r_region;
    logic [1:0]                          r_quarter;
    logic [7:0]                          r_x;
    logic [7:0]                          r_y;

    // First compute stage.
    logic [mtti_pkg::GridW-1:0]          w_gx;
    logic [mtti_pkg::GridW-1:0]          w_gy;
    logic                                w_lt;
    logic                                w_xge;
    logic [3:0]                          w_k;
    logic [mtti_pkg::Q6W-1:0]            w_q6;
    logic [mtti_pkg::SzpW-1:0]           w_szp;
    logic [mtti_pkg::DividendW-1:0]      w_num;
    logic [mtti_pkg::ProdW-1:0]          r_gxgy;
    logic [mtti_pkg::ProdW-1:0]          r_gxy;
    logic [mtti_pkg::KW-1:0]             r_k3;
    logic [mtti_pkg::StripW-1:0]         r_sbase;
    logic [mtti_pkg::GridW-1:0]          r_gx;
    logic                                r_lt;
    logic                                r_neg;
    logic [mtti_pkg::SzpW-1:0]           r_szp;

    // Second and third compute stages.
    logic [mtti_pkg::BaseW-1:0]          r_base;
    logic [mtti_pkg::OffsW-1:0]          r_offs;
    logic [mtti_pkg::OffsW-1:0]          w_offs;
    logic signed [mtti_pkg::PtW-1:0]     r_point;
    logic [mtti_pkg::SzW-1:0]            w_sz;
    logic                                w_oor;

    // Output register.
    logic                                r_out_valid;
    logic [mtti_pkg::PointW-1:0]         r_out_point;
    logic [mtti_pkg::SizeW-1:0]          r_out_size;

    // Item classification at the input.
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_action   = mtti_pkg::t_action'(i_action);
    assign w_in_range = (4'(i_station) < 4'(mtti_pkg::NumStations)) &&
                        (4'(i_region) < 4'(mtti_pkg::NumRegions));
    assign w_load     = w_in_acc && w_in_range && (w_action == mtti_pkg::ACT_LOAD);
    assign w_lookup   = w_in_range &&
                        (w_action == mtti_pkg::ACT_PAD || w_action == mtti_pkg::ACT_STRIP);
    // Entry is RegionsPerStation * station + region.
    assign w_entry    = {i_station, i_region};

    // A load stores the running sum (zero for entry 0) as its size base, then adds 24 times its height.
    assign w_sum_base = (w_entry == '0) ? '0 : r_sum;
    assign w_wdata    = '{grid_width:  i_load_grid_x,
                          grid_height: i_load_grid_y,
                          strip_base:  i_load_strip_base,
                          size_base:   w_sum_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_valid <= '0;
        end else if (w_load) begin
            r_sum            <= w_sum_base + mtti_pkg::SizeW'(i_load_grid_y) *
                                mtti_pkg::SizeW'(mtti_pkg::SizeStep);
            r_valid[w_entry] <= 1'b1;
        end
    end

    mtti_ram #(
        .Width ($bits(mtti_pkg::t_entry)),
        .Depth (mtti_pkg::EntryCount)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_entry),
        .i_wdata (w_wdata),
        .i_raddr (w_entry),
        .o_rdata (w_rdata)
    );

    // Table entry as seen by the lookup: entries never loaded read as zero.
    assign w_ent = r_hit ? mtti_pkg::t_entry'(w_rdata) : '0;
    assign w_gx  = w_ent.grid_width;
    assign w_gy  = w_ent.grid_height;
    assign w_lt  = r_y < w_gy;
    assign w_xge = r_x >= w_gx;

    // Quarter multiplier: 4 * region + quarter for pads, quarter for strips.
    assign w_k   = (r_act == mtti_pkg::ACT_PAD) ? {r_region, r_quarter} : {2'b00, r_quarter};
    assign w_q6  = mtti_pkg::Q6W'(r_quarter) * mtti_pkg::Q6W'(mtti_pkg::SizeQuarterMul);

    // Size index without the divided term.
    assign w_szp = mtti_pkg::SzpW'(w_ent.size_base) +
                   mtti_pkg::SzpW'(w_q6) * mtti_pkg::SzpW'(w_gy) +
                   (w_lt ? mtti_pkg::SzpW'({r_y, 1'b0})
                         : mtti_pkg::SzpW'({r_y, 2'b00}) - mtti_pkg::SzpW'({w_gy, 1'b0}));

    // Magnitude of the dividend; the sign is applied after division.
    assign w_num = w_lt ? (w_xge ? {r_x - w_gx, 1'b0} : {w_gx - r_x, 1'b0}) : {r_x, 1'b0};

    // Pad offset inside the quarter, two's complement.
    assign w_offs = r_lt ? mtti_pkg::OffsW'(r_gxy) + mtti_pkg::OffsW'(r_x) -
                           mtti_pkg::OffsW'(r_gx)
                         : mtti_pkg::OffsW'({r_gxy, 1'b0}) - mtti_pkg::OffsW'(r_gxgy) +
                           mtti_pkg::OffsW'(r_x);

    // Size index with the signed quotient, and the range check of both indices.
    assign w_sz  = r_neg ? mtti_pkg::SzW'(r_szp) - mtti_pkg::SzW'(w_div_rsp.quotient)
                         : mtti_pkg::SzW'(r_szp) + mtti_pkg::SzW'(w_div_rsp.quotient);
    assign w_oor = r_point[mtti_pkg::PtW-1] || (|r_point[mtti_pkg::PtW-2:mtti_pkg::PointW]) ||
                   w_sz[mtti_pkg::SzW-1] || (|w_sz[mtti_pkg::SzW-2:mtti_pkg::SizeW]);

    // Datapath registers, advanced by the sequencer state.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act     <= w_action;
            r_region  <= i_region;
            r_quarter <= i_quarter;
            r_x       <= i_pad_x;
            r_y       <= i_pad_y;
            r_hit     <= r_valid[w_entry];
        end
        if (r_state == mtti_pkg::S_READ) begin
            r_gxgy  <= mtti_pkg::ProdW'(w_gx) * mtti_pkg::ProdW'(w_gy);
            r_gxy   <= mtti_pkg::ProdW'(w_gx) * mtti_pkg::ProdW'(r_y);
            r_k3    <= mtti_pkg::KW'(w_k) * mtti_pkg::KW'(mtti_pkg::PerQuarterMul);
            r_sbase <= (r_act == mtti_pkg::ACT_STRIP) ? w_ent.strip_base : '0;
            r_gx    <= w_gx;
            r_lt    <= w_lt;
            r_neg   <= w_lt && !w_xge;
            r_szp   <= w_szp;
        end
        if (r_state == mtti_pkg::S_MUL) begin
            r_base <= mtti_pkg::BaseW'(r_k3) * mtti_pkg::BaseW'(r_gxgy) +
                      mtti_pkg::BaseW'(r_sbase);
            r_offs <= w_offs;
        end
        if (r_state == mtti_pkg::S_DIV) begin
            r_point <= $signed(mtti_pkg::PtW'(r_base)) + mtti_pkg::PtW'($signed(r_offs));
        end
    end

    // Pending result class.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= mtti_pkg::ST_OK;
        end else if (w_in_acc) begin
            if (w_load) begin
                r_pend <= mtti_pkg::ST_LOADED;
            end else if (w_lookup) begin
                r_pend <= mtti_pkg::ST_OK;
            end else begin
                r_pend <= mtti_pkg::ST_RANGE;
            end
        end else if (r_state == mtti_pkg::S_READ && w_gx == '0) begin
            r_pend <= mtti_pkg::ST_ZERO_WIDTH;
        end
    end

    mtti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtti_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtti_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_lookup ? mtti_pkg::S_READ : mtti_pkg::S_DONE;
                end
            end
            mtti_pkg::S_READ: begin
                n_state = (w_gx == '0) ? mtti_pkg::S_DONE : mtti_pkg::S_MUL;
            end
            mtti_pkg::S_MUL: begin
                n_state = mtti_pkg::S_DIV;
            end
            mtti_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = mtti_pkg::S_DONE;
                end
            end
            mtti_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = mtti_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtti_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready           = 1'b0;
        w_out_load           = 1'b0;
        w_div_req.start      = 1'b0;
        w_div_req.dividend   = w_num;
        w_div_req.divisor    = w_gx;
        case (r_state)
            mtti_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            mtti_pkg::S_READ: begin
                w_div_req.start = (w_gx != '0);
            end
            mtti_pkg::S_DONE: begin
                w_out_load = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_pend == mtti_pkg::ST_OK && !w_oor) begin
                r_out_status <= mtti_pkg::ST_OK;
                r_out_point  <= r_point[mtti_pkg::PointW-1:0];
                r_out_size   <= w_sz[mtti_pkg::SizeW-1:0];
            end else begin
                r_out_status <= (r_pend == mtti_pkg::ST_OK) ? mtti_pkg::ST_RANGE : r_pend;
                r_out_point  <= '0;
                r_out_size   <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_index = r_out_point;
    assign o_size_idx    = r_out_size;
    assign o_status      = r_out_status;

    `MTTI_ASSERT_NEXT(a_load_done, i_clk, i_rst_n, w_load, r_state == mtti_pkg::S_DONE && r_pend == mtti_pkg::ST_LOADED, "load did not go straight to result")
    `MTTI_ASSERT_IMPL(a_lookup_div, i_clk, i_rst_n, r_state == mtti_pkg::S_DONE && r_pend == mtti_pkg::ST_OK, w_div_rsp.done, "lookup result without finished division")
    `MTTI_ASSERT_IMPL(a_flag_zero, i_clk, i_rst_n, o_out_valid && o_status != mtti_pkg::ST_OK, o_point_index == '0 && o_size_idx == '0, "flagged result with nonzero indices")

endmodule
